// ===== rtl/floppy_step_tone_controller_macros.svh =====
// Assertion macros shared by the floppy step tone controller RTL
`ifndef FLOPPY_STEP_TONE_CONTROLLER_MACROS_SVH
`define FLOPPY_STEP_TONE_CONTROLLER_MACROS_SVH

// Consequent must hold in the cycle after the antecedent
`define FSC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("floppy step tone controller: next-cycle check failed");

// Consequent must hold in the same cycle as the antecedent
`define FSC_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("floppy step tone controller: same-cycle check failed");

`endif

// ===== rtl/fsc_pkg.sv =====
// Types and constants for the floppy step tone controller
`timescale 1ns / 1ps

package fsc_pkg;

    localparam int NUM_DRIVES = 3;
    localparam int DRV_IDX_W  = 2;
    localparam int MAX_TRACK  = 79;

    localparam logic [7:0]  TURN_POINT    = 8'(2 * MAX_TRACK - 1);
    localparam logic [7:0]  CMD_RESET     = 8'd100;
    localparam logic [7:0]  CMD_PERC      = 8'd101;
    localparam logic [15:0] PERIOD_IGNORE = 16'hFFFF;

    // Item kinds carried in tuser
    localparam logic [1:0] OP_STEP = 2'd0;
    localparam logic [1:0] OP_MS   = 2'd1;
    localparam logic [1:0] OP_RX   = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] REG_RELAY   = 2'd0;
    localparam logic [1:0] REG_LED     = 2'd1;
    localparam logic [1:0] REG_TIMEOUT = 2'd2;

    localparam logic [7:0] RELAY_MS_RST   = 8'd50;
    localparam logic [7:0] LED_MS_RST     = 8'd100;
    localparam logic [7:0] TIMEOUT_MS_RST = 8'd100;

    typedef enum logic [1:0] {
        DONE_NONE   = 2'd0,
        DONE_RESET  = 2'd1,
        DONE_PERC   = 2'd2,
        DONE_PERIOD = 2'd3
    } t_done;

    typedef struct packed {
        logic        tick;
        logic        clear;
        logic        load;
        logic [15:0] period;
    } t_drive_ctrl;

endpackage

// ===== rtl/fsc_drive.sv =====
// One drive: period counter, step toggle and half-step walk
`timescale 1ns / 1ps

module fsc_drive (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  fsc_pkg::t_drive_ctrl i_ctrl,
    output logic                o_step,
    output logic                o_dir
);

    logic [15:0] r_period, n_period;
    logic [15:0] r_count,  n_count;
    logic [7:0]  r_half,   n_half;
    logic        r_down,   n_down;
    logic        r_step,   n_step;
    logic        r_dir,    n_dir;
    logic [15:0] count_dec;

    assign count_dec = r_count - 16'd1;

    always_comb begin
        n_period = r_period;
        n_count  = r_count;
        n_half   = r_half;
        n_down   = r_down;
        n_step   = r_step;
        n_dir    = r_dir;
        if (i_ctrl.clear) begin
            n_period = '0;
            n_count  = '0;
            n_half   = '0;
            n_down   = 1'b0;
            n_dir    = 1'b1;
        end else if (i_ctrl.load) begin
            n_period = i_ctrl.period;
            n_count  = i_ctrl.period;
        end else if (i_ctrl.tick && r_period != 16'd0) begin
            if (count_dec != 16'd0) begin
                n_count = count_dec;
            end else begin
                // turn around at either end of the walk
                if (r_half == fsc_pkg::TURN_POINT) begin
                    n_dir  = 1'b1;
                    n_down = 1'b1;
                end else if (r_half == 8'd0) begin
                    n_dir  = 1'b0;
                    n_down = 1'b0;
                end
                n_step  = ~r_step;
                n_count = r_period;
                n_half  = n_down ? r_half - 8'd1 : r_half + 8'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= '0;
            r_count  <= '0;
            r_half   <= '0;
            r_down   <= 1'b0;
            r_step   <= 1'b1;
            r_dir    <= 1'b1;
        end else begin
            r_period <= n_period;
            r_count  <= n_count;
            r_half   <= n_half;
            r_down   <= n_down;
            r_step   <= n_step;
            r_dir    <= n_dir;
        end
    end

    assign o_step = r_step;
    assign o_dir  = r_dir;

endmodule

// ===== rtl/floppy_step_tone_controller.sv =====
// Top level of the floppy step tone controller
//
// Input stream: one beat per event. s_axis_tuser is the kind (step tick,
// millisecond tick, received byte); s_axis_tdata is the byte, used only
// for received bytes. Every accepted beat gives exactly one output beat
// carrying the step and direction levels of the drives, the relay and LED
// levels and a code for the command completed by that beat.
// The state is updated and the output beat is held in registers at the
// edge that accepts the input beat. Throughput is one beat per cycle while
// the receiver keeps taking beats; s_axis_tready is high whenever the
// output register is empty or being drained in the same cycle.
// When the receiver stalls, the output beat holds and s_axis_tready drops,
// so no state moves until the beat is taken.
// Configuration writes take effect at once; o_cfg_ready is always high and
// writes to an index beyond the register list are dropped.
// After reset: drives stopped, step and direction lines high, relay pulse
// running at its default length, LED off, parser idle.
`timescale 1ns / 1ps
`include "floppy_step_tone_controller_macros.svh"

module floppy_step_tone_controller (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,  // [7:0] rx_byte
    input  logic [1:0]  s_axis_tuser,  // [1:0] op
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [2:0] step_lines, [5:3] dir_lines, [6] relay_on, [7] led_on,
    // [9:8] command_done, [15:10] zero
    output logic [15:0] m_axis_tdata,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_HIGH,
        PH_LOW
    } t_phase;

    localparam int ND = fsc_pkg::NUM_DRIVES;

    logic                        accept;
    logic [7:0]                  rx_b;
    logic [7:0]                  rx_dec;
    logic [15:0]                 rx_period;

    logic [7:0]                  r_cfg_relay, r_cfg_led, r_cfg_timeout;
    t_phase                      r_phase, n_phase;
    logic [fsc_pkg::DRV_IDX_W-1:0] r_target, n_target;
    logic [7:0]                  r_high, n_high;
    logic [7:0]                  r_timeout, n_timeout;
    logic [7:0]                  r_relay, n_relay;
    logic [7:0]                  r_led, n_led;
    fsc_pkg::t_done              r_done, n_done;
    logic                        r_out_valid;
    logic                        rx_clear;
    logic                        rx_load;
    logic                        tick;

    logic [ND-1:0]               step_lvl;
    logic [ND-1:0]               dir_lvl;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;
    assign rx_b          = s_axis_tdata;
    assign rx_dec        = rx_b - 8'd1;
    assign rx_period     = {r_high, rx_b};
    assign tick          = accept && s_axis_tuser == fsc_pkg::OP_STEP;

    always_comb begin
        n_phase   = r_phase;
        n_target  = r_target;
        n_high    = r_high;
        n_timeout = r_timeout;
        n_relay   = r_relay;
        n_led     = r_led;
        n_done    = fsc_pkg::DONE_NONE;
        rx_clear  = 1'b0;
        rx_load   = 1'b0;
        if (accept) begin
            case (s_axis_tuser)
                fsc_pkg::OP_MS: begin
                    if (r_relay != 8'd0) n_relay = r_relay - 8'd1;
                    if (r_led != 8'd0)   n_led   = r_led - 8'd1;
                    if (r_timeout != 8'd0) begin
                        n_timeout = r_timeout - 8'd1;
                        // drop a half-received period command
                        if (r_timeout == 8'd1) n_phase = PH_IDLE;
                    end
                end
                fsc_pkg::OP_RX: begin
                    case (r_phase)
                        PH_HIGH: begin
                            n_high    = rx_b;
                            n_phase   = PH_LOW;
                            n_timeout = r_cfg_timeout;
                        end
                        PH_LOW: begin
                            n_phase   = PH_IDLE;
                            n_timeout = 8'd0;
                            if (rx_period != fsc_pkg::PERIOD_IGNORE) begin
                                if (r_led == 8'd0) n_led = r_cfg_led;
                                rx_load = 1'b1;
                                n_done  = fsc_pkg::DONE_PERIOD;
                            end
                        end
                        default: begin
                            n_phase = PH_IDLE;
                            if (rx_b == fsc_pkg::CMD_RESET) begin
                                if (r_led == 8'd0) n_led = r_cfg_led;
                                rx_clear = 1'b1;
                                n_done   = fsc_pkg::DONE_RESET;
                            end else if (rx_b == fsc_pkg::CMD_PERC) begin
                                if (r_led == 8'd0)   n_led   = r_cfg_led;
                                if (r_relay == 8'd0) n_relay = r_cfg_relay;
                                n_done = fsc_pkg::DONE_PERC;
                            end else if (rx_b != 8'd0 && rx_dec < 8'(ND)) begin
                                n_target  = rx_dec[fsc_pkg::DRV_IDX_W-1:0];
                                n_phase   = PH_HIGH;
                                n_timeout = r_cfg_timeout;
                            end
                        end
                    endcase
                end
                default: begin
                    // step ticks are handled in the drives; other kinds do nothing
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_relay   <= fsc_pkg::RELAY_MS_RST;
            r_cfg_led     <= fsc_pkg::LED_MS_RST;
            r_cfg_timeout <= fsc_pkg::TIMEOUT_MS_RST;
            r_phase       <= PH_IDLE;
            r_target      <= '0;
            r_high        <= '0;
            r_timeout     <= '0;
            r_relay       <= fsc_pkg::RELAY_MS_RST;
            r_led         <= '0;
            r_done        <= fsc_pkg::DONE_NONE;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    fsc_pkg::REG_RELAY:   r_cfg_relay   <= i_cfg_data;
                    fsc_pkg::REG_LED:     r_cfg_led     <= i_cfg_data;
                    fsc_pkg::REG_TIMEOUT: r_cfg_timeout <= i_cfg_data;
                    default: begin
                        // no register at this index
                    end
                endcase
            end
            r_phase   <= n_phase;
            r_target  <= n_target;
            r_high    <= n_high;
            r_timeout <= n_timeout;
            r_relay   <= n_relay;
            r_led     <= n_led;
            if (accept) begin
                r_done      <= n_done;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    for (genvar gi = 0; gi < ND; gi++) begin : g_drive
        fsc_pkg::t_drive_ctrl drv_ctrl;

        always_comb begin
            drv_ctrl.tick   = tick;
            drv_ctrl.clear  = rx_clear;
            drv_ctrl.load   = rx_load && r_target == fsc_pkg::DRV_IDX_W'(gi);
            drv_ctrl.period = rx_period;
        end

        fsc_drive u_drive (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (drv_ctrl),
            .o_step  (step_lvl[gi]),
            .o_dir   (dir_lvl[gi])
        );
    end

    // Drive and pulse state only moves on an accepted beat, so it matches
    // the held output beat for as long as the receiver stalls.
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'd0, r_done, (r_led != 8'd0), (r_relay != 8'd0),
                            dir_lvl, step_lvl};

    `FSC_ASSERT_NEXT(a_reset_done, accept && s_axis_tuser == fsc_pkg::OP_RX && r_phase == PH_IDLE && s_axis_tdata == fsc_pkg::CMD_RESET, m_axis_tvalid && r_done == fsc_pkg::DONE_RESET && dir_lvl == {ND{1'b1}})
    `FSC_ASSERT_NEXT(a_perc_led, accept && s_axis_tuser == fsc_pkg::OP_RX && r_phase == PH_IDLE && s_axis_tdata == fsc_pkg::CMD_PERC && r_cfg_led != 8'd0, r_led != 8'd0 && r_done == fsc_pkg::DONE_PERC)
    `FSC_ASSERT_SAME(a_stall_only, !s_axis_tready, r_out_valid && !m_axis_tready)

endmodule

// ===== bench/tb.sv =====
// Self-checking stream testbench for the floppy step tone controller
`timescale 1ns / 1ps

module tb;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] data;
    } t_tone_event;

    typedef struct packed {
        logic [fsc_pkg::NUM_DRIVES-1:0] step;
        logic [fsc_pkg::NUM_DRIVES-1:0] dir;
        logic                           relay;
        logic                           led;
        fsc_pkg::t_done                 done;
    } t_tone_levels;

    typedef enum logic [1:0] {
        PARSE_IDLE = 2'd0,
        PARSE_HIGH = 2'd1,
        PARSE_LOW  = 2'd2
    } t_parse_state;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'd0;   // [7:0] rx_byte
    logic [1:0]  s_axis_tuser = fsc_pkg::OP_STEP; // [1:0] op
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // [2:0] step_lines, [5:3] dir_lines, [6] relay_on, [7] led_on, [9:8] command_done
    logic [15:0] m_axis_tdata;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = fsc_pkg::REG_RELAY;
    logic [7:0]  i_cfg_data = 8'd0;

    floppy_step_tone_controller dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

    t_tone_event  events_to_send[$];
    t_tone_levels levels_due[$];
    int unsigned  send_gap_pct = 0;
    int unsigned  stall_pct = 0;
    int unsigned  fail_count = 0;
    int unsigned  beats_checked = 0;
    int unsigned  settings_used = 1;

    // Controller state as the predictor sees it
    logic [15:0]                    drv_period[fsc_pkg::NUM_DRIVES];
    logic [15:0]                    drv_count[fsc_pkg::NUM_DRIVES];
    logic [7:0]                     drv_pos[fsc_pkg::NUM_DRIVES];
    logic                           drv_down[fsc_pkg::NUM_DRIVES];
    logic [fsc_pkg::NUM_DRIVES-1:0] step_lv;
    logic [fsc_pkg::NUM_DRIVES-1:0] dir_lv;
    logic [7:0]                     relay_left;
    logic [7:0]                     led_left;
    logic [7:0]                     gap_left;
    t_parse_state                   parse;
    logic [1:0]                     target;
    logic [7:0]                     period_hi;
    logic [7:0]                     relay_len;
    logic [7:0]                     led_len;
    logic [7:0]                     gap_len;

    int unsigned n_period, n_stop, n_perc, n_dropped, n_turns;

    function automatic void reset_tone_state();
        for (int i = 0; i < fsc_pkg::NUM_DRIVES; i++) begin
            drv_period[i] = '0;
            drv_count[i]  = '0;
            drv_pos[i]    = '0;
            drv_down[i]   = 1'b0;
        end
        relay_len  = fsc_pkg::RELAY_MS_RST;
        led_len    = fsc_pkg::LED_MS_RST;
        gap_len    = fsc_pkg::TIMEOUT_MS_RST;
        step_lv    = '1;
        dir_lv     = '1;
        relay_left = relay_len;
        led_left   = '0;
        gap_left   = '0;
        parse      = PARSE_IDLE;
        target     = '0;
        period_hi  = '0;
    endfunction

    function automatic t_tone_levels advance_tone_state(logic [1:0] op, logic [7:0] rx_b);
        t_tone_levels res;
        logic [15:0]  p;
        res.done = fsc_pkg::DONE_NONE;
        case (op)
            fsc_pkg::OP_STEP: begin
                for (int i = 0; i < fsc_pkg::NUM_DRIVES; i++) begin
                    if (drv_period[i] != 0) begin
                        drv_count[i] = drv_count[i] - 16'd1;
                        if (drv_count[i] == 0) begin
                            // reverse at either end of the half-step walk
                            if (drv_pos[i] == fsc_pkg::TURN_POINT) begin
                                dir_lv[i]   = 1'b1;
                                drv_down[i] = 1'b1;
                                n_turns++;
                            end else if (drv_pos[i] == 0) begin
                                dir_lv[i]   = 1'b0;
                                drv_down[i] = 1'b0;
                            end
                            step_lv[i]   = ~step_lv[i];
                            drv_count[i] = drv_period[i];
                            drv_pos[i]   = drv_down[i] ? drv_pos[i] - 8'd1 : drv_pos[i] + 8'd1;
                        end
                    end
                end
            end
            fsc_pkg::OP_MS: begin
                if (relay_left != 0) relay_left--;
                if (led_left != 0) led_left--;
                if (gap_left != 0) begin
                    gap_left--;
                    if (gap_left == 0 && parse != PARSE_IDLE) begin
                        parse = PARSE_IDLE;
                        n_dropped++;
                    end
                end
            end
            fsc_pkg::OP_RX: begin
                case (parse)
                    PARSE_HIGH: begin
                        period_hi = rx_b;
                        parse     = PARSE_LOW;
                        gap_left  = gap_len;
                    end
                    PARSE_LOW: begin
                        p        = {period_hi, rx_b};
                        parse    = PARSE_IDLE;
                        gap_left = '0;
                        if (p != fsc_pkg::PERIOD_IGNORE) begin
                            if (led_left == 0) led_left = led_len;
                            drv_period[target] = p;
                            drv_count[target]  = p;
                            res.done = fsc_pkg::DONE_PERIOD;
                            if (p == 0) n_stop++;
                            else n_period++;
                        end
                    end
                    default: begin
                        parse = PARSE_IDLE;
                        if (rx_b == fsc_pkg::CMD_RESET) begin
                            if (led_left == 0) led_left = led_len;
                            for (int i = 0; i < fsc_pkg::NUM_DRIVES; i++) begin
                                drv_period[i] = '0;
                                drv_count[i]  = '0;
                                drv_pos[i]    = '0;
                                drv_down[i]   = 1'b0;
                            end
                            dir_lv   = '1;
                            res.done = fsc_pkg::DONE_RESET;
                        end else if (rx_b == fsc_pkg::CMD_PERC) begin
                            if (led_left == 0) led_left = led_len;
                            if (relay_left == 0) relay_left = relay_len;
                            res.done = fsc_pkg::DONE_PERC;
                            n_perc++;
                        end else if (rx_b >= 1 && rx_b <= fsc_pkg::NUM_DRIVES) begin
                            target   = 2'(rx_b - 8'd1);
                            parse    = PARSE_HIGH;
                            gap_left = gap_len;
                        end
                    end
                endcase
            end
            default: ;
        endcase
        res.step  = step_lv;
        res.dir   = dir_lv;
        res.relay = (relay_left != 0);
        res.led   = (led_left != 0);
        return res;
    endfunction

    always @(posedge i_clk) begin : drive_events
        t_tone_event next_ev;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                levels_due.push_back(advance_tone_state(s_axis_tuser, s_axis_tdata));
            // load the next beat once the current one is gone
            if (!s_axis_tvalid || s_axis_tready) begin
                if (events_to_send.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
                    next_ev = events_to_send.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser  <= next_ev.op;
                    s_axis_tdata  <= next_ev.data;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : check_levels
        t_tone_levels want;
        t_tone_levels got;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.step  = m_axis_tdata[2:0];
                got.dir   = m_axis_tdata[5:3];
                got.relay = m_axis_tdata[6];
                got.led   = m_axis_tdata[7];
                got.done  = fsc_pkg::t_done'(m_axis_tdata[9:8]);
                if (levels_due.size() == 0) begin
                    if (fail_count < 10)
                        $display("%0t: output beat %h with nothing expected", $time, m_axis_tdata);
                    fail_count++;
                end else begin
                    want = levels_due.pop_front();
                    if (got.step !== want.step || got.dir !== want.dir
                            || got.relay !== want.relay || got.led !== want.led
                            || got.done !== want.done) begin
                        if (fail_count < 10) begin
                            $display(
                                "%0t: beat %0d expected step %b dir %b relay %b led %b done %0d",
                                $time, beats_checked,
                                want.step, want.dir, want.relay, want.led, want.done);
                            $display("    got step %b dir %b relay %b led %b done %0d",
                                     got.step, got.dir, got.relay, got.led, got.done);
                        end
                        fail_count++;
                    end
                    beats_checked++;
                end
            end
            m_axis_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic queue_event(input logic [1:0] op, input logic [7:0] data);
        t_tone_event ev;
        ev.op   = op;
        ev.data = data;
        events_to_send.push_back(ev);
    endtask

    task automatic queue_ticks(input logic [1:0] op, input int unsigned n);
        for (int i = 0; i < n; i++)
            queue_event(op, 8'($urandom_range(255)));
    endtask

    // Millisecond ticks between data bytes; sometimes land just short of or on the timeout
    task automatic queue_data_gap();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 15)
            queue_ticks(fsc_pkg::OP_MS, $urandom_range(1, 3));
        else if (r < 30 && gap_len <= 30)
            queue_ticks(fsc_pkg::OP_MS, gap_len - $urandom_range(1));
    endtask

    task automatic queue_period_traffic(input int unsigned n);
        int unsigned start;
        int unsigned r;
        logic [15:0] p;
        start = events_to_send.size();
        while (events_to_send.size() - start < n) begin
            r = $urandom_range(99);
            if (r < 40) begin
                queue_ticks(fsc_pkg::OP_STEP, $urandom_range(1, 40));
            end else if (r < 52) begin
                queue_ticks(fsc_pkg::OP_MS, $urandom_range(1, 12));
            end else if (r < 75) begin
                r = $urandom_range(99);
                if (r < 55) p = 16'($urandom_range(1, 6));
                else if (r < 65) p = 16'd0;
                else if (r < 72) p = fsc_pkg::PERIOD_IGNORE;
                else if (r < 80) p = {8'($urandom_range(1)), 8'($urandom_range(100, 101))};
                else if (r < 90) p = 16'($urandom_range(7, 64));
                else p = 16'($urandom_range(16'hFFFF));
                if ($urandom_range(9) == 0)
                    queue_event(fsc_pkg::OP_RX, 8'($urandom_range(255)));
                else
                    queue_event(fsc_pkg::OP_RX, 8'($urandom_range(1, fsc_pkg::NUM_DRIVES)));
                queue_data_gap();
                queue_event(fsc_pkg::OP_RX, p[15:8]);
                // leave some commands without their low byte
                if ($urandom_range(9) != 0) begin
                    queue_data_gap();
                    queue_event(fsc_pkg::OP_RX, p[7:0]);
                end
            end else if (r < 78) begin
                queue_event(fsc_pkg::OP_RX, fsc_pkg::CMD_RESET);
            end else if (r < 86) begin
                queue_event(fsc_pkg::OP_RX, fsc_pkg::CMD_PERC);
            end else begin
                queue_event(fsc_pkg::OP_RX, 8'($urandom_range(255)));
            end
        end
    endtask

    task automatic drain_stream();
        int unsigned waited;
        waited = 0;
        while ((events_to_send.size() != 0 || s_axis_tvalid || levels_due.size() != 0)
                && waited < 20000) begin
            @(posedge i_clk);
            if (events_to_send.size() == 0) waited++;
        end
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [7:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            fsc_pkg::REG_RELAY:   relay_len = val;
            fsc_pkg::REG_LED:     led_len   = val;
            fsc_pkg::REG_TIMEOUT: gap_len   = val;
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
    endtask

    task automatic run_setting(input logic [7:0] relay_ms, input logic [7:0] led_ms,
                               input logic [7:0] gap_ms, input int unsigned send_pct,
                               input int unsigned hold_pct, input int unsigned n);
        drain_stream();
        write_register(fsc_pkg::REG_RELAY, relay_ms);
        write_register(fsc_pkg::REG_LED, led_ms);
        write_register(fsc_pkg::REG_TIMEOUT, gap_ms);
        send_gap_pct = send_pct;
        stall_pct    = hold_pct;
        settings_used++;
        queue_period_traffic(n);
    endtask

    initial begin
        reset_tone_state();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: ignored bytes, both commands, period edge cases, stop
        queue_event(fsc_pkg::OP_STEP, 8'h00);
        queue_event(fsc_pkg::OP_MS, 8'hFF);
        queue_event(fsc_pkg::OP_RX, 8'd0);
        queue_event(fsc_pkg::OP_RX, 8'd255);
        queue_event(fsc_pkg::OP_RX, 8'(fsc_pkg::NUM_DRIVES + 1));
        queue_event(fsc_pkg::OP_RX, fsc_pkg::CMD_PERC);
        queue_event(fsc_pkg::OP_RX, fsc_pkg::CMD_RESET);
        queue_event(fsc_pkg::OP_RX, 8'd1);
        queue_event(fsc_pkg::OP_RX, fsc_pkg::PERIOD_IGNORE[15:8]);
        queue_event(fsc_pkg::OP_RX, fsc_pkg::PERIOD_IGNORE[7:0]);
        queue_event(fsc_pkg::OP_RX, 8'd2);
        queue_event(fsc_pkg::OP_RX, fsc_pkg::CMD_RESET);
        queue_event(fsc_pkg::OP_RX, fsc_pkg::CMD_PERC);
        queue_event(fsc_pkg::OP_RX, 8'd3);
        queue_event(fsc_pkg::OP_RX, 8'h00);
        queue_event(fsc_pkg::OP_RX, 8'h01);
        queue_ticks(fsc_pkg::OP_STEP, 2);
        queue_event(fsc_pkg::OP_RX, 8'd2);
        queue_event(fsc_pkg::OP_RX, 8'h00);
        queue_event(fsc_pkg::OP_RX, 8'h00);
        queue_event(fsc_pkg::OP_RX, 8'd3);
        queue_event(fsc_pkg::OP_RX, 8'h00);
        queue_event(fsc_pkg::OP_RX, fsc_pkg::CMD_RESET);
        queue_event(fsc_pkg::OP_STEP, 8'h5A);

        run_setting(8'd255, 8'd255, 8'd255, 47, 0, 200);
        run_setting(8'd1, 8'd1, 8'd1, 0, 47, 200);
        run_setting(8'd7, 8'd3, 8'd5, 16, 16, 200);
        run_setting(8'd20, 8'd12, 8'd30, 0, 0, 200);
        run_setting(8'd50, 8'd100, 8'd100, 47, 0, 200);

        drain_stream();
        repeat (4) @(posedge i_clk);
        if (levels_due.size() != 0) begin
            $display("%0d expected output beats never arrived", levels_due.size());
            fail_count++;
        end
        $display("%0d beats checked under %0d register settings; %0d period loads, %0d stops,",
                 beats_checked, settings_used, n_period, n_stop);
        $display("%0d percussion hits, %0d timed-out commands, %0d turns at the far end",
                 n_perc, n_dropped, n_turns);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
